/* hdl/mexp_pkg.sv */
`timescale 1ns / 1ps

package mexp_pkg;

   // Residue width: the prime sits just below 2^30
   localparam int RES_W             = 30;
   localparam int BASE_BITS         = 63;
   localparam int EXP_FIELD_BITS    = 63;
   localparam int EXPONENT_BITS_DEF = 63;

   typedef logic [RES_W-1:0] residue_type;

   localparam residue_type PRIME = 30'd1000000007;
   localparam residue_type ONE   = 30'd1;

   // Barrett factor floor(2^(2*RES_W) / PRIME), fits in 31 bits
   localparam logic [31:0] BARRETT_MU = 32'((64'd1 << (2 * RES_W)) / 64'd1000000007);

endpackage

/* hdl/modular_exponentiation_top.sv */
`timescale 1ns / 1ps

// Channel   Ports                                   Dir   Moves
// req       req_valid/req_ready, req_base/exponent  in    one request: base, exponent
// rsp       rsp_valid/rsp_ready, rsp_power_mod      out   one result per request
//
// Sequence, from the accepting edge to the edge that raises rsp_valid: reduce
// the base (two direct Barrett passes on the shared multiplier), then the exponent
// LSB first up to its highest set bit: multiply + square per set bit, square only
// per clear bit, then load the output register. A zero exponent skips the base
// reduction and the exponent steps and goes straight to the output load.
// Reset is synchronous, active high; no clearing pass. req_ready is high only when
// idle; a result waiting on rsp_ready stalls only the final cycle of the next request.
module modular_exponentiation_top #(
   parameter int EXPONENT_BITS = mexp_pkg::EXPONENT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [mexp_pkg::BASE_BITS-1:0]      req_base,
   input  logic [mexp_pkg::EXP_FIELD_BITS-1:0] req_exponent,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mexp_pkg::RES_W-1:0]          rsp_power_mod
);

   localparam logic [2:0] S_IDLE = 3'd0;   // waiting for a request
   localparam logic [2:0] S_RED  = 3'd1;   // base mod p in progress
   localparam logic [2:0] S_BIT  = 3'd2;   // look at next exponent bit
   localparam logic [2:0] S_WACC = 3'd3;   // waiting on acc * sq
   localparam logic [2:0] S_WSQ  = 3'd4;   // waiting on sq * sq

   logic [2:0]                   state_ff, state_in;
   mexp_pkg::residue_type        acc_ff, acc_in;
   mexp_pkg::residue_type        sq_ff, sq_in;
   logic [EXPONENT_BITS-1:0]     rem_ff, rem_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   mexp_pkg::residue_type        rsp_data_ff, rsp_data_in;

   logic                         req_accept;
   logic [EXPONENT_BITS-1:0]     exp_masked;

   logic                         red_start;
   logic                         red_done;
   mexp_pkg::residue_type        red_result;
   logic                         red_mm_start;
   logic [2*mexp_pkg::RES_W-1:0] red_mm_x;

   logic                         mm_start;
   logic                         mm_direct;
   mexp_pkg::residue_type        mm_a;
   mexp_pkg::residue_type        mm_b;
   logic [2*mexp_pkg::RES_W-1:0] mm_x;
   logic                         mm_done;
   mexp_pkg::residue_type        mm_result;

   mexp_reduce u_reduce (
      .clock     (clock),
      .reset     (reset),
      .start     (red_start),
      .value     (req_base),
      .done      (red_done),
      .result    (red_result),
      .mm_start  (red_mm_start),
      .mm_x      (red_mm_x),
      .mm_done   (mm_done),
      .mm_result (mm_result)
   );

   mexp_mulmod u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .start  (mm_start),
      .direct (mm_direct),
      .a      (mm_a),
      .b      (mm_b),
      .x      (mm_x),
      .done   (mm_done),
      .result (mm_result)
   );

   assign req_ready     = (state_ff == S_IDLE);
   assign req_accept    = req_valid && req_ready;
   assign exp_masked    = req_exponent[EXPONENT_BITS-1:0];
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_power_mod = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      sq_in        = sq_ff;
      rem_in       = rem_ff;
      rsp_data_in  = rsp_data_ff;
      // output slot drains on a handshake
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      red_start    = 1'b0;
      mm_start     = 1'b0;
      mm_direct    = 1'b0;
      mm_a         = sq_ff;
      mm_b         = sq_ff;
      mm_x         = red_mm_x;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               acc_in = mexp_pkg::ONE;
               rem_in = exp_masked;
               // zero exponent: result is 1, base never needed
               if (exp_masked == '0) begin
                  state_in = S_BIT;
               end else begin
                  red_start = 1'b1;
                  state_in  = S_RED;
               end
            end
         end
         S_RED: begin
            // the reducer owns the multiplier here
            mm_start  = red_mm_start;
            mm_direct = 1'b1;
            if (red_done) begin
               sq_in    = red_result;
               state_in = S_BIT;
            end
         end
         S_BIT: begin
            if (rem_ff == '0) begin
               // hold here until the output register is free
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = acc_ff;
                  state_in     = S_IDLE;
               end
            end else if (rem_ff[0]) begin
               mm_start = 1'b1;
               mm_a     = acc_ff;
               state_in = S_WACC;
            end else begin
               mm_start = 1'b1;
               state_in = S_WSQ;
            end
         end
         S_WACC: begin
            if (mm_done) begin
               acc_in   = mm_result;
               // square issued back to back with the multiply result
               mm_start = 1'b1;
               state_in = S_WSQ;
            end
         end
         S_WSQ: begin
            if (mm_done) begin
               sq_in    = mm_result;
               rem_in   = rem_ff >> 1;
               state_in = S_BIT;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff      <= acc_in;
      sq_ff       <= sq_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* hdl/mexp_reduce.sv */
`timescale 1ns / 1ps

// Base reduction on the shared mulmod, no multiplier of its own.
// base = hi * 2^30 + lo; r1 = hi mod p, then r = (r1 * 2^30 + lo) mod p.
// Both passes are direct Barrett reductions (x below 2^60).
module mexp_reduce (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [mexp_pkg::BASE_BITS-1:0]    value,
   output logic                              done,
   output mexp_pkg::residue_type             result,
   output logic                              mm_start,
   output logic [2*mexp_pkg::RES_W-1:0]      mm_x,
   input  logic                              mm_done,
   input  mexp_pkg::residue_type             mm_result
);

   localparam logic [1:0] R_IDLE  = 2'd0;
   localparam logic [1:0] R_ISSUE = 2'd1;
   localparam logic [1:0] R_HI    = 2'd2;
   localparam logic [1:0] R_LO    = 2'd3;

   localparam int X_W = 2 * mexp_pkg::RES_W;

   logic [1:0]                        state_ff, state_in;
   logic [mexp_pkg::BASE_BITS-1:0]    val_ff, val_in;

   always_comb begin
      state_in = state_ff;
      val_in   = val_ff;
      mm_start = 1'b0;
      mm_x     = X_W'(val_ff[mexp_pkg::BASE_BITS-1:mexp_pkg::RES_W]);
      done     = 1'b0;
      result   = mm_result;
      case (state_ff)
         R_IDLE: begin
            if (start) begin
               val_in   = value;
               state_in = R_ISSUE;
            end
         end
         R_ISSUE: begin
            // high part first
            mm_start = 1'b1;
            state_in = R_HI;
         end
         R_HI: begin
            if (mm_done) begin
               mm_start = 1'b1;
               mm_x     = {mm_result, val_ff[mexp_pkg::RES_W-1:0]};
               state_in = R_LO;
            end
         end
         R_LO: begin
            if (mm_done) begin
               done     = 1'b1;
               state_in = R_IDLE;
            end
         end
         default: begin
            state_in = R_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= R_IDLE;
      end else begin
         state_ff <= state_in;
      end
      val_ff <= val_in;
   end

endmodule

/* hdl/mexp_mulmod.sv */
`timescale 1ns / 1ps

// Modular multiply on one shared 32x32 multiplier, Barrett reduction.
// start -> AB (a*b) -> MU (quotient estimate) -> QP (q*p) -> FIX (done).
// With direct set, x (below 2^60) is loaded as is and AB is skipped.
// A new start is taken in IDLE or in the FIX cycle.
module mexp_mulmod (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           direct,
   input  mexp_pkg::residue_type          a,
   input  mexp_pkg::residue_type          b,
   input  logic [2*mexp_pkg::RES_W-1:0]   x,
   output logic                           done,
   output mexp_pkg::residue_type          result
);

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_AB   = 3'd1;
   localparam logic [2:0] PH_MU   = 3'd2;
   localparam logic [2:0] PH_QP   = 3'd3;
   localparam logic [2:0] PH_FIX  = 3'd4;

   localparam int W = mexp_pkg::RES_W;

   logic [2:0]            phase_ff, phase_in;
   mexp_pkg::residue_type a_ff, a_in;
   mexp_pkg::residue_type b_ff, b_in;
   logic [2*W-1:0]        x_ff, x_in;
   logic [W:0]            q_ff, q_in;
   logic [W+1:0]          qp_ff, qp_in;

   logic [31:0]           mul_a;
   logic [31:0]           mul_b;
   logic [63:0]           prod;

   logic [W+1:0]          p1;
   logic [W+1:0]          p2;
   logic [W+1:0]          diff;
   logic [W+1:0]          diff_p1;
   logic [W+1:0]          diff_p2;

   assign prod = mul_a * mul_b;

   always_comb begin
      case (phase_ff)
         PH_AB: begin
            mul_a = 32'(a_ff);
            mul_b = 32'(b_ff);
         end
         PH_MU: begin
            mul_a = 32'(x_ff[2*W-1:W-1]);
            mul_b = mexp_pkg::BARRETT_MU;
         end
         PH_QP: begin
            mul_a = 32'(q_ff);
            mul_b = 32'(mexp_pkg::PRIME);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Remainder estimate is below 3p, so two corrections at most
   always_comb begin
      p1      = {2'b00, mexp_pkg::PRIME};
      p2      = {1'b0, mexp_pkg::PRIME, 1'b0};
      diff    = x_ff[W+1:0] - qp_ff;
      diff_p1 = diff - p1;
      diff_p2 = diff - p2;
      if (diff >= p2) begin
         result = diff_p2[W-1:0];
      end else if (diff >= p1) begin
         result = diff_p1[W-1:0];
      end else begin
         result = diff[W-1:0];
      end
      done = (phase_ff == PH_FIX);
   end

   always_comb begin
      phase_in = phase_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      x_in     = x_ff;
      q_in     = q_ff;
      qp_in    = qp_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               if (direct) begin
                  x_in     = x;
                  phase_in = PH_MU;
               end else begin
                  phase_in = PH_AB;
                  a_in     = a;
                  b_in     = b;
               end
            end
         end
         PH_AB: begin
            x_in     = prod[2*W-1:0];
            phase_in = PH_MU;
         end
         PH_MU: begin
            q_in     = prod[2*W+1:W+1];
            phase_in = PH_QP;
         end
         PH_QP: begin
            qp_in    = prod[W+1:0];
            phase_in = PH_FIX;
         end
         PH_FIX: begin
            if (start) begin
               if (direct) begin
                  x_in     = x;
                  phase_in = PH_MU;
               end else begin
                  phase_in = PH_AB;
                  a_in     = a;
                  b_in     = b;
               end
            end else begin
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
      a_ff  <= a_in;
      b_ff  <= b_in;
      x_ff  <= x_in;
      q_ff  <= q_in;
      qp_ff <= qp_in;
   end

endmodule
